@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset
`define UKS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle
`define UKS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication failed");

`else

`define UKS_ASSERT(lbl, clk, rstn, prop)
`define UKS_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ sv/uks_pkg.sv @@
// ----------------------------------------------------------------------------
// uks_pkg
// Types and constants shared by the unique key stack and its storage.
// ----------------------------------------------------------------------------
`default_nettype none

package uks_pkg;

  // Default number of stack entries
  localparam int UKS_DEPTH = 16;

  // Fixed field widths
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2
  } uks_mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_UNDER = 2'd2,
    STAT_OVER  = 2'd3
  } uks_status_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } uks_state_e;

  // Request word
  typedef struct packed {
    logic [1:0]               mode;
    logic signed [KEY_W-1:0]  push_key;
    logic signed [DATA_W-1:0] push_data;
  } uks_req_t;

  // Result word
  typedef struct packed {
    uks_status_e              status;
    logic signed [KEY_W-1:0]  top_key;
    logic signed [DATA_W-1:0] top_data;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
  } uks_rsp_t;

endpackage

`default_nettype wire

@@ sv/uks_mem.sv @@
// ----------------------------------------------------------------------------
// uks_mem
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module uks_mem
  import uks_pkg::*;
#(
  parameter int DEPTH = UKS_DEPTH,
  parameter int WIDTH = KEY_W + DATA_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/unique_key_stack_unit.sv @@
// ----------------------------------------------------------------------------
// unique_key_stack_unit
// Bounded LIFO of key/data pairs with unique keys, kept in one entry memory.
// ----------------------------------------------------------------------------
// Issue a word with start while busy is low. A push walks the stored keys one
// memory read per cycle looking for a duplicate, so it holds busy until it
// has compared every stored key (at most DEPTH), or stops early when a
// duplicate turns up; a push to an empty stack, mode 3 and a pop or peek on
// an empty stack finish in the accept cycle, and a pop or peek of a stored
// entry passes through S_READ for the memory read. The result is shown on
// rsp_o with done_o high for exactly one cycle, starting the cycle after the
// last busy cycle; it must be taken then, as it is never held. No clearing
// pass follows reset: only stored entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module unique_key_stack_unit
  import uks_pkg::*;
#(
  parameter int DEPTH = UKS_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire uks_req_t req_i,
  output logic          done_o,
  output uks_rsp_t      rsp_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = KEY_W + DATA_W;

  uks_state_e              state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    done_q, done_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [1:0]              mode_q;
  logic signed [KEY_W-1:0] key_q;
  logic [DATA_W-1:0]       data_q;
  uks_rsp_t                rsp_q, rsp_d;

  logic                    accept;
  logic [CW-1:0]           last;
  logic [AW-1:0]           last_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [MW-1:0]           mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [MW-1:0]           mem_rdata;

  // Build a result word
  function automatic uks_rsp_t make_rsp(uks_status_e st, logic [KEY_W-1:0] tk,
                                        logic [DATA_W-1:0] td, logic [CW-1:0] cnt);
    uks_rsp_t r;
    r.status      = st;
    r.top_key     = tk;
    r.top_data    = td;
    r.entry_count = CNT_W'(cnt);
    r.is_empty    = (cnt == '0);
    return r;
  endfunction

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign last      = count_q - CW'(1);
  assign last_addr = last[AW-1:0];

  // Entry memory: key in the upper half, data in the lower half
  uks_mem #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequence the scan, read and write-back
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = {key_q, data_q};
    mem_raddr = idx_q + AW'(1);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.mode)
            MODE_PUSH: begin
              if (count_q == '0) begin
                mem_we    = 1'b1;
                mem_wdata = {req_i.push_key, req_i.push_data};
                count_d   = CW'(1);
                rsp_d     = make_rsp(STAT_OK, '0, '0, CW'(1));
                done_d    = 1'b1;
              end else begin
                mem_raddr = '0;
                idx_d     = '0;
                state_d   = S_SCAN;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (count_q == '0) begin
                rsp_d  = make_rsp(STAT_UNDER, '0, '0, count_q);
                done_d = 1'b1;
              end else begin
                mem_raddr = last_addr;
                state_d   = S_READ;
              end
            end
            default: begin
              rsp_d  = make_rsp(STAT_OK, '0, '0, count_q);
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (mem_rdata[MW-1 -: KEY_W] == key_q) begin
          rsp_d   = make_rsp(STAT_DUP, '0, '0, count_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (CW'(idx_q) == last) begin
          if (count_q == CW'(DEPTH)) begin
            rsp_d = make_rsp(STAT_OVER, '0, '0, count_q);
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + CW'(1);
            rsp_d   = make_rsp(STAT_OK, '0, '0, count_q + CW'(1));
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      S_READ: begin
        if (mode_q == MODE_POP) begin
          count_d = last;
        end
        rsp_d   = make_rsp(STAT_OK, mem_rdata[MW-1 -: KEY_W],
                           mem_rdata[DATA_W-1:0],
                           (mode_q == MODE_POP) ? last : count_q);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Capture the request word and advance payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rsp_q <= rsp_d;
    if (accept) begin
      mode_q <= req_i.mode;
      key_q  <= req_i.push_key;
      data_q <= req_i.push_data;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Fill level never passes the bound and moves by at most one per cycle
  `UKS_ASSERT(a_cnt_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `UKS_ASSERT(a_cnt_step, clk_i, rst_ni, (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)))
  // Leaving a multi-cycle operation always delivers a result
  `UKS_ASSERT_IMP(a_busy_done, clk_i, rst_ni, $fell(busy), done_q)
  // Underflow is only reported for an empty stack
  `UKS_ASSERT_IMP(a_under_empty, clk_i, rst_ni, done_q && (rsp_q.status == STAT_UNDER), rsp_q.is_empty && (rsp_q.entry_count == '0))
  // The key scan stays inside the stored entries
  `UKS_ASSERT_IMP(a_scan_range, clk_i, rst_ni, state_q == S_SCAN, CW'(idx_q) < count_q)

endmodule

`default_nettype wire

@@ bench/tb_unique_key_stack_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unique_key_stack_unit
// Self-checking bench for the unique key stack. A directed prologue and a
// long run of random push/pop/peek/unused-mode words in fill, drain and mixed
// phases go through a queue-fed driver. Each accepted word runs a behavioral
// stack copy, and the monitor compares every result word field by field.
// ----------------------------------------------------------------------------

module tb_unique_key_stack_unit;
  import uks_pkg::*;

  // Unused operation code: the block leaves the stack alone
  localparam logic [1:0] MODE_NOP = 2'd3;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_WORDS = 650;
  localparam int PHASE_LEN    = 40;
  localparam int DRAIN_EVERY  = 160;
  localparam int QUIET_FIRST  = 300;
  localparam int QUIET_LAST   = 420;
  localparam int IDLE_PCT     = 13;
  localparam int TAIL_CYCLES  = 2 * UKS_DEPTH + 8;
  localparam int STALL_LIMIT  = 2000;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } load_phase_e;

  // Queued word plus a flag to wait for all results before issuing it
  typedef struct {
    uks_req_t word;
    bit       settle;
  } stack_cmd_t;

  logic     clk_i    = 1'b0;
  logic     rst_ni   = 1'b0;
  logic     start    = 1'b0;
  uks_req_t req_word = '0;
  logic     busy;
  logic     done;
  uks_rsp_t rsp_word;

  stack_cmd_t pending_q[$];
  uks_rsp_t   stack_result_q[$];

  // Behavioral copy of the stack
  logic [KEY_W-1:0]  stack_keys[UKS_DEPTH];
  logic [DATA_W-1:0] stack_data[UKS_DEPTH];
  int                stack_fill = 0;
  int                peak_fill  = 0;

  int fail_cnt    = 0;
  int words_sent  = 0;
  int results_got = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int stall_cycles = 0;

  unique_key_stack_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_word),
    .done_o (done),
    .rsp_o  (rsp_word)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Apply one word to the stack copy and return the result it should give
  function automatic uks_rsp_t apply_stack_op(input uks_req_t word);
    uks_rsp_t res;
    bit       hit;
    res        = '0;
    res.status = STAT_OK;
    hit        = 1'b0;
    case (word.mode)
      MODE_PUSH: begin
        for (int i = 0; i < stack_fill; i++) begin
          if (stack_keys[i] == word.push_key) hit = 1'b1;
        end
        if (hit) begin
          res.status = STAT_DUP;
        end else if (stack_fill >= UKS_DEPTH) begin
          res.status = STAT_OVER;
        end else begin
          stack_keys[stack_fill] = word.push_key;
          stack_data[stack_fill] = word.push_data;
          stack_fill++;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (stack_fill == 0) begin
          res.status = STAT_UNDER;
        end else begin
          res.top_key  = stack_keys[stack_fill-1];
          res.top_data = stack_data[stack_fill-1];
          if (word.mode == MODE_POP) stack_fill--;
        end
      end
      default: ;
    endcase
    if (stack_fill > peak_fill) peak_fill = stack_fill;
    res.entry_count = CNT_W'(stack_fill);
    res.is_empty    = (stack_fill == 0);
    return res;
  endfunction

  function automatic void queue_word(input logic [1:0] mode, input logic [31:0] key,
                                     input logic [31:0] data, input bit settle);
    stack_cmd_t cmd;
    cmd.word.mode      = mode;
    cmd.word.push_key  = key;
    cmd.word.push_data = data;
    cmd.settle         = settle;
    pending_q.push_back(cmd);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Driver: issue queued words, idle at random outside the quiet span, hold a settle word until drained
  always @(posedge clk_i) begin
    bit         taken;
    bit         hold;
    bit         quiet;
    stack_cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        stack_result_q.push_back(apply_stack_op(req_word));
        words_sent++;
      end
      if (taken || !start) begin
        quiet = (words_sent >= QUIET_FIRST) && (words_sent < QUIET_LAST);
        hold  = (pending_q.size() == 0) ||
                (!quiet && ($urandom_range(99) < IDLE_PCT));
        if (!hold && pending_q[0].settle && (stack_result_q.size() != 0)) hold = 1'b1;
        if (hold) begin
          start <= 1'b0;
        end else begin
          nxt = pending_q.pop_front();
          req_word <= nxt.word;
          start    <= 1'b1;
        end
      end
    end
  end

  // Monitor: take each result word and compare with the oldest expectation
  always @(posedge clk_i) begin
    uks_rsp_t want;
    if (rst_ni && done) begin
      results_got++;
      status_seen[rsp_word.status]++;
      if (stack_result_q.size() == 0) begin
        $error("result word with no expectation pending");
        fail_cnt++;
      end else begin
        want = stack_result_q.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_word.status));
        check_field("top_key", want.top_key, rsp_word.top_key);
        check_field("top_data", want.top_data, rsp_word.top_data);
        check_field("entry_count", 32'(want.entry_count), 32'(rsp_word.entry_count));
        check_field("is_empty", 32'(want.is_empty), 32'(rsp_word.is_empty));
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    load_phase_e phase;
    int          roll;
    int          push_pct;
    int          pop_pct;
    logic [1:0]  mode;
    logic [31:0] key;

    // Underflow and unused mode on an empty stack
    queue_word(MODE_POP, 32'h0, 32'h0, 1'b0);
    queue_word(MODE_PEEK, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    queue_word(MODE_NOP, 32'h1234_5678, 32'h9abc_def0, 1'b0);
    // Extreme keys and data
    queue_word(MODE_PUSH, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    queue_word(MODE_PUSH, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    queue_word(MODE_PUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_word(MODE_PUSH, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    // Duplicate of the bottom key
    queue_word(MODE_PUSH, 32'h8000_0000, 32'h0000_5555, 1'b0);
    queue_word(MODE_PEEK, 32'h0, 32'h0, 1'b0);
    queue_word(MODE_NOP, 32'h0, 32'h0, 1'b0);
    queue_word(MODE_POP, 32'h0, 32'h0, 1'b1);
    // Fill to the top, then duplicate and overflow on a full stack
    for (int j = 0; j < UKS_DEPTH - 3; j++) begin
      queue_word(MODE_PUSH, 32'(100 + j), ~32'(j), 1'b0);
    end
    queue_word(MODE_PUSH, 32'h7fff_ffff, 32'h0bad_0bad, 1'b0);
    queue_word(MODE_PUSH, 32'h0000_1234, 32'h0000_4321, 1'b1);
    queue_word(MODE_PEEK, 32'h0, 32'h0, 1'b0);

    // Random words in fill, drain and mixed phases; small key pool for duplicates
    phase = PH_MIX;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % PHASE_LEN == 0) phase = load_phase_e'($urandom_range(2));
      case (phase)
        PH_FILL:  begin push_pct = 70; pop_pct = 15; end
        PH_DRAIN: begin push_pct = 20; pop_pct = 60; end
        default:  begin push_pct = 45; pop_pct = 35; end
      endcase
      roll = $urandom_range(99);
      if (roll < push_pct)                mode = MODE_PUSH;
      else if (roll < push_pct + pop_pct) mode = MODE_POP;
      else if (roll < 95)                 mode = MODE_PEEK;
      else                                mode = MODE_NOP;
      if ($urandom_range(1)) key = $urandom;
      else                   key = 32'($urandom_range(23)) - 32'd12;
      queue_word(mode, key, $urandom, (i % DRAIN_EVERY) == DRAIN_EVERY / 2);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all words to go in and all results to come back
    @(posedge clk_i);
    while ((pending_q.size() != 0) || start || (stack_result_q.size() != 0)) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("issued %0d words, checked %0d results, deepest stack %0d of %0d",
             words_sent, results_got, peak_fill, UKS_DEPTH);
    $display("status mix: ok %0d, duplicate %0d, underflow %0d, overflow %0d",
             status_seen[STAT_OK], status_seen[STAT_DUP], status_seen[STAT_UNDER],
             status_seen[STAT_OVER]);
    if (fail_cnt == 0 && stack_result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
